FILE: rtl/core/amv_pkg.sv
// Package for the adjacency matrix validator: sizes, status codes, sequencer states
// and the structs passed between the top level and the reachability unit.
// No dependencies.
package amv_pkg;

   localparam int MAX_VERTICES  = 32;
   localparam int WEIGHT_BITS   = 32;
   localparam int MIN_VERTICES  = 2;

   localparam int VIDX_BITS     = $clog2(MAX_VERTICES);
   localparam int RAM_DEPTH     = MAX_VERTICES * MAX_VERTICES;
   localparam int RAM_ADDR_BITS = 2 * VIDX_BITS;

   localparam int VC_BITS       = 6;
   localparam int VCX_BITS      = VC_BITS + 1;
   localparam int IDX_BITS      = 6;
   localparam logic [IDX_BITS-1:0] IDX_MAX = {IDX_BITS{1'b1}};

   localparam int REQ_DATA_BITS = ((WEIGHT_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_NOT_SQUARE    = 2'd1,
      STATUS_NEGATIVE      = 2'd2,
      STATUS_NOT_CONNECTED = 2'd3
   } amv_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_REACH,
      ST_FINISH
   } amv_state_type;

   typedef struct packed {
      logic                 en;
      logic [VIDX_BITS-1:0] row;
      logic [VIDX_BITS-1:0] col;
      logic                 edge_on;
   } amv_edge_wr_type;

   typedef struct packed {
      logic done;
      logic connected;
   } amv_reach_rsp_type;

endpackage

FILE: rtl/core/amv_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module amv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/amv_reach.sv
// Edge bit matrix and iterative reachability unit: one reached vertex is expanded per cycle.
// Depends on amv_pkg.
module amv_reach (
   input  logic                        clock,
   input  logic                        reset,
   input  amv_pkg::amv_edge_wr_type    edge_wr,
   input  logic                        start,
   input  logic [amv_pkg::VC_BITS-1:0] vertex_count,
   output amv_pkg::amv_reach_rsp_type  reach_rsp
);
   import amv_pkg::*;

   logic [MAX_VERTICES-1:0] edge_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] reached_ff, reached_in;
   logic [MAX_VERTICES-1:0] expanded_ff, expanded_in;
   logic                    busy_ff, busy_in;
   logic [MAX_VERTICES-1:0] all_mask;
   logic [MAX_VERTICES-1:0] pending;
   logic [VIDX_BITS-1:0]    sel;

   always_ff @(posedge clock) begin
      if (edge_wr.en) begin
         edge_ff[edge_wr.row][edge_wr.col] <= edge_wr.edge_on;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         all_mask[i] = ({1'b0, vertex_count} > VCX_BITS'(i));
      end
   end

   assign pending = reached_ff & ~expanded_ff;

   // Lowest reached vertex whose row has not been merged yet.
   always_comb begin
      sel = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (pending[i]) begin
            sel = VIDX_BITS'(i);
         end
      end
   end

   always_comb begin
      reached_in  = reached_ff;
      expanded_in = expanded_ff;
      busy_in     = busy_ff;
      if (start) begin
         reached_in  = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
         expanded_in = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (|pending) begin
            reached_in       = reached_ff | (edge_ff[sel] & all_mask);
            expanded_in[sel] = 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         reached_ff  <= '0;
         expanded_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         reached_ff  <= reached_in;
         expanded_ff <= expanded_in;
      end
   end

   assign reach_rsp.done      = busy_ff && !(|pending);
   assign reach_rsp.connected = (reached_ff == all_mask);

endmodule

FILE: rtl/core/adjacency_matrix_validator_unit.sv
// Top level of the adjacency matrix validator: entry sequencer, shape and sign checks,
// weight RAM and reachability unit. Depends on amv_pkg, amv_ram and amv_reach.
//
//   channel | direction | contents
//   req     | in        | tdata: weight [31:0]; tuser: end_of_row; tlast: last_entry
//   rsp     | out       | tdata: status [1:0], directed [2], weighted [3], zeros [7:4]
//   csr     | in        | wr_data: vertex_count [5:0]
//
// Entries are accepted only in IDLE: the transposed weight is read from the RAM at
// acceptance and compared and stored in the next cycle, in ENTRY.
// After the final entry the sequencer goes to FINISH, through a reachability pass in
// REACH when shape, vertex count and signs are good.
// Reset is synchronous; the weight RAM and edge matrix are not cleared.
// A result waits in the output register while new entries are accepted; only
// the next final entry stalls until that result has been taken.
module adjacency_matrix_validator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [amv_pkg::REQ_DATA_BITS-1:0] req_tdata,  // weight
   input  logic                              req_tuser,  // end_of_row
   input  logic                              req_tlast,  // last_entry
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [amv_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // status, directed, weighted
   input  logic                              csr_wr_en,
   input  logic [amv_pkg::VC_BITS-1:0]       csr_wr_data
);
   import amv_pkg::*;

   amv_state_type state_ff, state_in;

   logic [WEIGHT_BITS-1:0] w_ff;
   logic                   eor_ff;
   logic                   last_ff;
   logic [VC_BITS-1:0]     vc_ff;
   logic [IDX_BITS-1:0]    row_ff, row_in;
   logic [IDX_BITS-1:0]    col_ff, col_in;
   logic                   shape_ff, shape_in;
   logic                   neg_ff, neg_in;
   logic                   asym_ff, asym_in;
   logic                   heavy_ff, heavy_in;
   amv_status_type         status_ff, status_in;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   logic                   accept;
   logic                   ram_wr_en;
   logic [WEIGHT_BITS-1:0] ram_rd_data;
   logic                   reach_start;
   logic                   finish_fire;
   amv_edge_wr_type        edge_wr;
   amv_reach_rsp_type      reach_rsp;

   logic                   vc_ok;
   logic                   store_ok;
   logic                   end_row;
   logic                   w_neg;
   logic                   w_heavy;
   logic                   shape_e;
   logic                   shape_final;
   logic [IDX_BITS-1:0]    row_e;
   logic [IDX_BITS-1:0]    col_e;
   logic                   neg_e;
   logic                   asym_e;
   logic                   need_reach;

   assign accept = req_tvalid && req_tready;

   // Checks on the entry held in w_ff, using the counters as they stood before it.
   always_comb begin
      vc_ok    = ({1'b0, vc_ff} >= VCX_BITS'(MIN_VERTICES)) &&
                 ({1'b0, vc_ff} <= VCX_BITS'(MAX_VERTICES));
      store_ok = vc_ok && (row_ff < vc_ff) && (col_ff < vc_ff);
      end_row  = eor_ff || last_ff;
      w_neg    = w_ff[WEIGHT_BITS-1];
      w_heavy  = !w_neg && (|w_ff[WEIGHT_BITS-2:1]);
      neg_e    = neg_ff || w_neg;
      asym_e   = asym_ff || (store_ok && !shape_ff && (col_ff < row_ff) &&
                             (ram_rd_data != w_ff));

      shape_e = shape_ff || !store_ok;
      row_e   = row_ff;
      col_e   = col_ff;
      if (end_row) begin
         if ((VCX_BITS'(col_ff) + VCX_BITS'(1)) != VCX_BITS'(vc_ff)) begin
            shape_e = 1'b1;
         end
         col_e = '0;
         if (row_ff == IDX_MAX) begin
            shape_e = 1'b1;
         end else begin
            row_e = row_ff + IDX_BITS'(1);
         end
      end else begin
         if (col_ff == IDX_MAX) begin
            shape_e = 1'b1;
         end else begin
            col_e = col_ff + IDX_BITS'(1);
         end
      end
      shape_final = shape_e || (last_ff && (row_e != vc_ff));
      need_reach  = !shape_final && vc_ok && !neg_e;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (need_reach) begin
               state_in = ST_REACH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_REACH: begin
            if (reach_rsp.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      reach_start = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_ENTRY: begin
            ram_wr_en   = store_ok;
            reach_start = last_ff && need_reach;
         end
         ST_REACH:  ;
         ST_FINISH: finish_fire = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   assign edge_wr.en      = ram_wr_en;
   assign edge_wr.row     = row_ff[VIDX_BITS-1:0];
   assign edge_wr.col     = col_ff[VIDX_BITS-1:0];
   assign edge_wr.edge_on = |w_ff;

   // Pass state updates.
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      shape_in  = shape_ff;
      neg_in    = neg_ff;
      asym_in   = asym_ff;
      heavy_in  = heavy_ff;
      status_in = status_ff;
      if (state_ff == ST_ENTRY) begin
         row_in   = row_e;
         col_in   = col_e;
         shape_in = shape_final;
         neg_in   = neg_e;
         asym_in  = asym_e;
         heavy_in = heavy_ff || w_heavy;
         if (shape_final || !vc_ok) begin
            status_in = STATUS_NOT_SQUARE;
         end else begin
            status_in = STATUS_NEGATIVE;
         end
      end else if (state_ff == ST_REACH && reach_rsp.done) begin
         status_in = reach_rsp.connected ? STATUS_OK : STATUS_NOT_CONNECTED;
      end else if (finish_fire) begin
         row_in   = '0;
         col_in   = '0;
         shape_in = 1'b0;
         neg_in   = 1'b0;
         asym_in  = 1'b0;
         heavy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vc_ff        <= VC_BITS'(MIN_VERTICES);
         row_ff       <= '0;
         col_ff       <= '0;
         shape_ff     <= 1'b0;
         neg_ff       <= 1'b0;
         asym_ff      <= 1'b0;
         heavy_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            vc_ff <= csr_wr_data;
         end
         row_ff   <= row_in;
         col_ff   <= col_in;
         shape_ff <= shape_in;
         neg_ff   <= neg_in;
         asym_ff  <= asym_in;
         heavy_ff <= heavy_in;
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (accept) begin
         w_ff    <= req_tdata[WEIGHT_BITS-1:0];
         eor_ff  <= req_tuser;
         last_ff <= req_tlast;
      end
      if (finish_fire) begin
         rsp_data_ff <= {{(RSP_DATA_BITS-4){1'b0}}, heavy_ff, asym_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The transposed entry is read at acceptance; it belongs to an earlier row
   // whenever the comparison is made.
   amv_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({row_ff[VIDX_BITS-1:0], col_ff[VIDX_BITS-1:0]}),
      .wr_data (w_ff),
      .rd_en   (accept),
      .rd_addr ({col_ff[VIDX_BITS-1:0], row_ff[VIDX_BITS-1:0]}),
      .rd_data (ram_rd_data)
   );

   amv_reach u_reach (
      .clock        (clock),
      .reset        (reset),
      .edge_wr      (edge_wr),
      .start        (reach_start),
      .vertex_count (vc_ff),
      .reach_rsp    (reach_rsp)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for adjacency_matrix_validator_unit: streams matrices, predicts each verdict
// and compares it with what the block returns. Depends on amv_pkg and the validator RTL.
module tb_top;
   import amv_pkg::*;

   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic                   row_end;
      logic                   final_word;
   } matrix_word_type;

   typedef struct {
      amv_status_type status;
      logic           directed;
      logic           weighted;
   } matrix_verdict_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // weight
   logic                     req_tuser = 1'b0;  // end_of_row
   logic                     req_tlast = 1'b0;  // last_entry
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;  // status [1:0], directed [2], weighted [3]
   logic                     csr_wr_en = 1'b0;
   logic [VC_BITS-1:0]       csr_wr_data = '0;

   // Predictor state, mirroring the block.
   logic [WEIGHT_BITS-1:0]  weights [MAX_VERTICES][MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
   logic [VC_BITS-1:0]      vertex_count = VC_BITS'(MIN_VERTICES);
   logic [IDX_BITS-1:0]     row_idx = '0;
   logic [IDX_BITS-1:0]     col_idx = '0;
   logic                    shape_bad = 1'b0;
   logic                    saw_negative = 1'b0;
   logic                    saw_asymmetry = 1'b0;
   logic                    saw_heavy = 1'b0;

   matrix_verdict_type pending_verdicts [$];
   matrix_word_type    matrix_words [$];
   int                 failures = 0;
   int                 words_sent = 0;
   int                 stall_cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   adjacency_matrix_validator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void flag_failure(input string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, what);
   endfunction

   // Applies one accepted word to the predicted state; the final word of a matrix
   // queues the verdict that the block must return.
   function automatic void absorb_word(input logic [WEIGHT_BITS-1:0] w, input logic eor,
                                       input logic last);
      logic                    negative;
      logic                    count_ok;
      logic [IDX_BITS-1:0]     r;
      logic [IDX_BITS-1:0]     c;
      logic [MAX_VERTICES:0]   span;
      logic [MAX_VERTICES-1:0] full;
      logic [MAX_VERTICES-1:0] reached;
      logic [MAX_VERTICES-1:0] grown;
      int                      sweep;
      int                      v;
      matrix_verdict_type      verdict;

      negative = w[WEIGHT_BITS-1];
      count_ok = (vertex_count >= MIN_VERTICES) && (vertex_count <= MAX_VERTICES);
      r = row_idx;
      c = col_idx;
      if (negative) saw_negative = 1'b1;
      else if (w > 1) saw_heavy = 1'b1;

      if (!count_ok || r >= vertex_count || c >= vertex_count) begin
         shape_bad = 1'b1;
      end else begin
         // The transposed weight only counts while the rows so far are well formed.
         if (!shape_bad && c < r && weights[c][r] != w) saw_asymmetry = 1'b1;
         weights[r][c] = w;
         adjacency[r][c] = (w != '0);
      end

      if (eor || last) begin
         if ({1'b0, c} + 7'd1 != {1'b0, vertex_count}) shape_bad = 1'b1;
         col_idx = '0;
         if (row_idx == IDX_MAX) shape_bad = 1'b1;
         else row_idx = row_idx + 1'b1;
      end else if (col_idx == IDX_MAX) begin
         shape_bad = 1'b1;
      end else begin
         col_idx = col_idx + 1'b1;
      end

      if (last) begin
         if (row_idx != vertex_count) shape_bad = 1'b1;
         if (shape_bad || !count_ok) begin
            verdict.status = STATUS_NOT_SQUARE;
         end else if (saw_negative) begin
            verdict.status = STATUS_NEGATIVE;
         end else begin
            span = ({{MAX_VERTICES{1'b0}}, 1'b1} << vertex_count) - 1'b1;
            full = span[MAX_VERTICES-1:0];
            reached = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
            for (sweep = 0; sweep < MAX_VERTICES; sweep++) begin
               grown = reached;
               for (v = 0; v < vertex_count; v++)
                  if (reached[v]) grown = grown | (adjacency[v] & full);
               if (grown == reached) break;
               reached = grown;
            end
            verdict.status = (reached == full) ? STATUS_OK : STATUS_NOT_CONNECTED;
         end
         verdict.directed = saw_asymmetry;
         verdict.weighted = saw_heavy;
         pending_verdicts = {pending_verdicts, verdict};
         row_idx = '0;
         col_idx = '0;
         shape_bad = 1'b0;
         saw_negative = 1'b0;
         saw_asymmetry = 1'b0;
         saw_heavy = 1'b0;
      end
   endfunction

   task automatic send_word(input logic [WEIGHT_BITS-1:0] w, input logic eor, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      req_tuser <= eor;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_word(w, eor, last);
      words_sent++;
   endtask

   task automatic send_row2(input logic [WEIGHT_BITS-1:0] w0, input logic [WEIGHT_BITS-1:0] w1,
                            input logic last);
      send_word(w0, 1'b0, 1'b0);
      send_word(w1, 1'b1, last);
   endtask

   task automatic send_matrix_words();
      matrix_word_type word;
      while (matrix_words.size() != 0) begin
         word = matrix_words.pop_front();
         send_word(word.weight, word.row_end, word.final_word);
      end
   endtask

   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // The block must be idle for a register write: no verdict owed and the
   // reachability pass finished.
   task automatic set_vertex_count(input logic [VC_BITS-1:0] count);
      drain_verdicts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_count = count;
   endtask

   function automatic logic [WEIGHT_BITS-1:0] pick_weight(input int neg_pct, input int heavy_pct);
      logic [WEIGHT_BITS-1:0] w;
      int                     r;
      r = $urandom_range(99);
      w = $urandom;
      if (r < neg_pct) begin
         case ($urandom_range(2))
            0: w = '1;
            1: w = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
            default: w[WEIGHT_BITS-1] = 1'b1;
         endcase
      end else if (r < neg_pct + heavy_pct) begin
         case ($urandom_range(2))
            0: w = 2;
            1: w = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
            default: w[WEIGHT_BITS-1] = 1'b0;
         endcase
      end else begin
         w = 1;
      end
      return w;
   endfunction

   // Fills matrix_words with a well formed n by n matrix of random content.
   task automatic build_matrix(input int n);
      logic [WEIGHT_BITS-1:0] grid [MAX_VERTICES][MAX_VERTICES];
      int                     density;
      int                     neg_pct;
      int                     heavy_pct;
      logic                   mirror;
      matrix_word_type        word;
      density = $urandom_range(15, 100);
      neg_pct = ($urandom_range(99) < 25) ? $urandom_range(1, 10) : 0;
      heavy_pct = ($urandom_range(99) < 40) ? $urandom_range(5, 60) : 0;
      mirror = ($urandom_range(99) < 65);
      matrix_words.delete();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (mirror && j < i) grid[i][j] = grid[j][i];
            else if ($urandom_range(99) < density) grid[i][j] = pick_weight(neg_pct, heavy_pct);
            else grid[i][j] = '0;
            word.weight = grid[i][j];
            word.row_end = (j == n - 1);
            word.final_word = (i == n - 1) && (j == n - 1);
            matrix_words = {matrix_words, word};
         end
      end
   endtask

   // Breaks the shape of the matrix in matrix_words; the final word stays final.
   task automatic mutate_matrix(input int n);
      matrix_word_type word;
      int              idx;
      int              keep;
      idx = $urandom_range(matrix_words.size() - 2);
      case ($urandom_range(5))
         0: matrix_words.delete(idx);
         1: begin
            word = matrix_words[idx];
            word.final_word = 1'b0;
            matrix_words.insert(idx, word);
         end
         2: begin
            word = matrix_words[idx];
            word.row_end = ~word.row_end;
            matrix_words[idx] = word;
         end
         3: begin
            word = matrix_words[$];
            word.row_end = 1'b0;
            matrix_words[$] = word;
         end
         4: begin
            keep = ($urandom_range(n - 2) + 1) * n;
            while (matrix_words.size() > keep) void'(matrix_words.pop_back());
            word = matrix_words[$];
            word.final_word = 1'b1;
            matrix_words[$] = word;
         end
         default: begin
            word = matrix_words[$];
            word.final_word = 1'b0;
            matrix_words[$] = word;
            for (int j = 0; j < n; j++) begin
               word.weight = pick_weight(5, 20);
               word.row_end = (j == n - 1);
               word.final_word = (j == n - 1);
               matrix_words = {matrix_words, word};
            end
         end
      endcase
   endtask

   function automatic logic [VC_BITS-1:0] pick_vertex_count();
      int r;
      r = $urandom_range(99);
      if (r < 65) return VC_BITS'($urandom_range(2, 5));
      if (r < 85) return VC_BITS'($urandom_range(6, 10));
      if (r < 93) return VC_BITS'($urandom_range(11, 16));
      if (r < 96) return VC_BITS'($urandom_range(1));
      return VC_BITS'($urandom_range(MAX_VERTICES + 1, 63));
   endfunction

   task automatic test_directed_cases();
      // vertex_count still holds its reset value of two here.
      send_row2(0, 1, 1'b0);
      send_row2(1, 0, 1'b1);
      send_row2(0, 0, 1'b0);
      send_row2(0, 0, 1'b1);
      send_row2(0, '1, 1'b0);
      send_row2('1, 0, 1'b1);
      send_row2(32'h7FFF_FFFF, 1, 1'b0);
      send_row2(1, 32'h8000_0000, 1'b1);
      send_row2(0, 1, 1'b0);
      send_row2(0, 0, 1'b1);
      // A row that runs one word too long.
      send_word(0, 1'b0, 1'b0);
      send_word(1, 1'b0, 1'b0);
      send_word(1, 1'b1, 1'b0);
      send_row2(1, 0, 1'b1);
      // A row cut short, then a matrix ended without its row mark.
      send_word(1, 1'b1, 1'b0);
      send_row2(1, 0, 1'b1);
      send_row2(0, 1, 1'b0);
      send_word(1, 1'b0, 1'b0);
      send_word(0, 1'b0, 1'b1);
      // One row too many, then one too few.
      send_row2(0, 1, 1'b0);
      send_row2(1, 0, 1'b0);
      send_row2(0, 0, 1'b1);
      send_row2(0, 1, 1'b1);
   endtask

   task automatic test_index_saturation();
      set_vertex_count(VC_BITS'(2));
      for (int i = 0; i < 70; i++) send_word($urandom, 1'b0, i == 69);
      for (int i = 0; i < 70; i++) send_word(i, 1'b1, i == 69);
   endtask

   task automatic test_vertex_count_extremes();
      set_vertex_count(VC_BITS'(0));
      build_matrix(2);
      send_matrix_words();
      set_vertex_count(VC_BITS'(1));
      send_word(1, 1'b1, 1'b1);
      set_vertex_count(VC_BITS'(MAX_VERTICES + 1));
      build_matrix(3);
      send_matrix_words();
      set_vertex_count(VC_BITS'(63));
      build_matrix(2);
      send_matrix_words();
      // The largest legal count, fed a matrix with far too few rows.
      set_vertex_count(VC_BITS'(MAX_VERTICES));
      build_matrix(4);
      send_matrix_words();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int word_budget);
      int goal;
      int matrices_left;
      int n;
      int r;
      int burst;
      send_idle_pct = sender_idle;
      recv_stall_pct = receiver_stall;
      goal = words_sent + word_budget;
      matrices_left = 0;
      while (words_sent < goal) begin
         if (matrices_left == 0) begin
            set_vertex_count(pick_vertex_count());
            matrices_left = $urandom_range(3, 8);
         end
         if (vertex_count >= MIN_VERTICES && vertex_count <= MAX_VERTICES) begin
            n = int'(vertex_count);
         end else begin
            n = $urandom_range(2, 4);
         end
         r = $urandom_range(99);
         if (r < 93) begin
            build_matrix(n);
            if (r >= 70) mutate_matrix(n);
            send_matrix_words();
         end else begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
               send_word($urandom, $urandom_range(99) < 30, i == burst - 1);
         end
         matrices_left--;
      end
   endtask

   always @(posedge clock) begin : verdict_check
      matrix_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            flag_failure($sformatf("unexpected verdict word %h", rsp_tdata));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[1:0] !== want.status || rsp_tdata[2] !== want.directed ||
                rsp_tdata[3] !== want.weighted)
               flag_failure($sformatf(
                  {"verdict mismatch: expected status %0d directed %0b weighted %0b,",
                   " got %0d %0b %0b"},
                  want.status, want.directed, want.weighted,
                  rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[3]));
         end
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         adjacency[i] = '0;
         for (int j = 0; j < MAX_VERTICES; j++) weights[i][j] = '0;
      end
      send_idle_pct = 35;
      recv_stall_pct = 83;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_index_saturation();
      test_vertex_count_extremes();
      test_random_traffic(35, 83, 240);
      test_random_traffic(83, 35, 240);
      test_random_traffic(0, 0, 240);
      drain_verdicts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
